// ===== hw/rtl/kwm_pkg.sv =====
package kwm_pkg;

    localparam int MAX_WAYS  = 16;
    localparam int KEY_WORDS = 4;
    localparam int WORD_BITS = 32;

    // one heap slot: flag, source way, clamped order, key words (word 0 most significant)
    typedef struct packed {
        logic                                end_f;
        logic [3:0]                          way;
        logic [2:0]                          order;
        logic [KEY_WORDS-1:0][WORD_BITS-1:0] label;
    } t_rec;

    // lexicographic compare over the shorter order, shorter order wins a full tie
    function automatic logic key_less(input t_rec a, input t_rec b);
        logic [2:0] n;
        logic       found;
        logic       res;
        n     = (a.order < b.order) ? a.order : b.order;
        found = 1'b0;
        res   = (a.order < b.order);
        for (int i = 0; i < KEY_WORDS; i++) begin
            if (!found && (3'(i) < n) && (a.label[i] != b.label[i])) begin
                res   = (a.label[i] < b.label[i]);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/kway_merge_heap_core.sv =====
// K-way merge engine on a binary min-heap held in a 16-slot record memory.
// Input channel (i_valid / o_stall): first one head word per way, the way
// field giving the heap slot; heads with a way not below the way count are
// dropped. When the last head arrives the heap is built and the smallest head
// is emitted. After that each input word is the next record of the way just
// emitted; it replaces the top, is sifted down and the new top is emitted.
// Output channel (o_valid / i_stall): one result word per emitted minimum,
// held in an output register until taken. o_all_done marks an end-of-way top;
// later inputs are taken and dropped until reset or a way-count write.
// A merge word is sifted down one heap level at a time: left read, right
// read, then compare and write back, all through the single record memory;
// the next word is taken once the new top has been emitted.
// Head words are taken one per cycle.
// The heap build after loading fetches each inner node in turn (ST_BLD, ST_BLD2) and sifts it down.
// A result not yet taken waits in the output register; the block goes on with
// the next word and holds in its emit step, input stalled, until it is taken.
// Reset (i_rst_n low, synchronous) sets the way count to 1 and restarts
// loading; memory contents are undefined until loaded.
module kway_merge_heap_core
    import kwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_way,
    input  logic        i_end_of_way,
    input  logic [2:0]  i_key_order,
    input  logic [31:0] i_label_0,
    input  logic [31:0] i_label_1,
    input  logic [31:0] i_label_2,
    input  logic [31:0] i_label_3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_top_way,
    output logic [2:0]  o_top_order,
    output logic [31:0] o_top_label_0,
    output logic [31:0] o_top_label_1,
    output logic [31:0] o_top_label_2,
    output logic [31:0] o_top_label_3,
    output logic        o_all_done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BLD  = 3'd1;
    localparam logic [2:0] ST_BLD2 = 3'd2;
    localparam logic [2:0] ST_RDL  = 3'd3;
    localparam logic [2:0] ST_RDR  = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    t_rec       mem [MAX_WAYS];
    t_rec       r_rdata;

    logic [2:0] r_state, n_state;
    logic [4:0] r_nw;
    logic [4:0] r_loaded, n_loaded;
    logic       r_fin, n_fin;
    logic       r_build, n_build;
    logic [3:0] r_bi, n_bi;
    logic [3:0] r_pos, n_pos;
    logic [3:0] r_bidx, n_bidx;
    t_rec       r_cur, n_cur;
    t_rec       r_best, n_best;
    t_rec       r_top, n_top;
    logic       r_oval, n_oval;
    t_rec       r_out, n_out;

    logic       mem_we;
    logic [3:0] mem_wa;
    t_rec       mem_wd;
    logic [3:0] mem_ra;

    logic [4:0] ways_n;
    logic [4:0] lidx, ridx;
    t_rec       in_rec;
    logic [2:0] ord_c;
    logic       in_acc;

    // clamp the way count
    assign ways_n = (r_nw == 5'd0) ? 5'd1 :
                    ((r_nw > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : r_nw);
    assign lidx   = {r_pos, 1'b1};
    assign ridx   = {r_pos, 1'b0} + 5'd2;

    // incoming record, clamped and end-of-way normalised
    always_comb begin
        ord_c = i_key_order;
        if (ord_c == 3'd0) ord_c = 3'd1;
        if (ord_c > 3'(KEY_WORDS)) ord_c = 3'(KEY_WORDS);
        in_rec.end_f = i_end_of_way;
        in_rec.way   = i_way;
        if (i_end_of_way) begin
            in_rec.order    = 3'd1;
            in_rec.label[0] = '1;
            in_rec.label[1] = '0;
            in_rec.label[2] = '0;
            in_rec.label[3] = '0;
        end else begin
            in_rec.order    = ord_c;
            in_rec.label[0] = i_label_0;
            in_rec.label[1] = i_label_1;
            in_rec.label[2] = i_label_2;
            in_rec.label[3] = i_label_3;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && (r_state == ST_IDLE);

    // control and heap sequencing
    always_comb begin
        n_state  = r_state;
        n_loaded = r_loaded;
        n_fin    = r_fin;
        n_build  = r_build;
        n_bi     = r_bi;
        n_pos    = r_pos;
        n_bidx   = r_bidx;
        n_cur    = r_cur;
        n_best   = r_best;
        n_top    = r_top;
        n_oval   = r_oval && i_stall;
        n_out    = r_out;
        mem_we   = 1'b0;
        mem_wa   = r_pos;
        mem_wd   = r_cur;
        mem_ra   = lidx[3:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !r_fin) begin
                    if (r_loaded < ways_n) begin
                        if ({1'b0, i_way} < ways_n) begin
                            mem_we   = 1'b1;
                            mem_wa   = i_way;
                            mem_wd   = in_rec;
                            if (i_way == 4'd0) n_top = in_rec;
                            n_loaded = r_loaded + 5'd1;
                            if (r_loaded + 5'd1 == ways_n) begin
                                if (ways_n == 5'd1) begin
                                    n_state = ST_EMIT;
                                end else begin
                                    n_build = 1'b1;
                                    n_bi    = 4'((ways_n - 5'd2) >> 1);
                                    n_state = ST_BLD;
                                end
                            end
                        end
                    end else begin
                        // replace the top, keeping its way
                        n_cur     = in_rec;
                        n_cur.way = r_top.way;
                        n_pos     = 4'd0;
                        n_build   = 1'b0;
                        n_state   = ST_RDL;
                    end
                end
            end
            ST_BLD: begin
                mem_ra  = r_bi;
                n_state = ST_BLD2;
            end
            ST_BLD2: begin
                n_cur   = r_rdata;
                n_pos   = r_bi;
                n_state = ST_RDL;
            end
            ST_RDL: begin
                if (lidx < ways_n) begin
                    mem_ra  = lidx[3:0];
                    n_state = ST_RDR;
                end else begin
                    // leaf reached: settle the record here
                    mem_we = 1'b1;
                    if (r_pos == 4'd0) n_top = r_cur;
                    if (r_build && r_bi != 4'd0) begin
                        n_bi    = r_bi - 4'd1;
                        n_state = ST_BLD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_RDR: begin
                mem_ra = ridx[3:0];
                if (key_less(r_rdata, r_cur)) begin
                    n_best = r_rdata;
                    n_bidx = lidx[3:0];
                end else begin
                    n_best = r_cur;
                    n_bidx = r_pos;
                end
                n_state = ST_CMP;
            end
            ST_CMP: begin
                mem_we = 1'b1;
                if (ridx < ways_n && key_less(r_rdata, r_best)) begin
                    mem_wd = r_rdata;
                    if (r_pos == 4'd0) n_top = r_rdata;
                    n_pos   = ridx[3:0];
                    n_state = ST_RDL;
                end else if (r_bidx != r_pos) begin
                    mem_wd = r_best;
                    if (r_pos == 4'd0) n_top = r_best;
                    n_pos   = r_bidx;
                    n_state = ST_RDL;
                end else begin
                    if (r_pos == 4'd0) n_top = r_cur;
                    if (r_build && r_bi != 4'd0) begin
                        n_bi    = r_bi - 4'd1;
                        n_state = ST_BLD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_oval || !i_stall) begin
                    n_oval = 1'b1;
                    n_out  = r_top;
                    if (r_top.end_f) n_fin = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_we) begin
            n_loaded = 5'd0;
            n_fin    = 1'b0;
        end
    end

    // record memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nw     <= 5'd1;
            r_loaded <= 5'd0;
            r_fin    <= 1'b0;
            r_build  <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_nw <= i_cfg_data;
            r_loaded <= n_loaded;
            r_fin    <= n_fin;
            r_build  <= n_build;
            r_oval   <= n_oval;
        end
        r_bi   <= n_bi;
        r_pos  <= n_pos;
        r_bidx <= n_bidx;
        r_cur  <= n_cur;
        r_best <= n_best;
        r_top  <= n_top;
        r_out  <= n_out;
    end

    assign o_valid       = r_oval;
    assign o_top_way     = r_out.way;
    assign o_top_order   = r_out.order;
    assign o_top_label_0 = r_out.label[0];
    assign o_top_label_1 = r_out.label[1];
    assign o_top_label_2 = r_out.label[2];
    assign o_top_label_3 = r_out.label[3];
    assign o_all_done    = r_out.end_f;

endmodule
